FILE: sv/sliding_median_filter_top_macros.svh
`ifndef SLIDING_MEDIAN_FILTER_TOP_MACROS_SVH
`define SLIDING_MEDIAN_FILTER_TOP_MACROS_SVH

// same-cycle implication, checked on clock, off while reset is high
`define SMF_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on clock, off while reset is high
`define SMF_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/smf_pkg.sv
package smf_pkg;

   localparam int RADIUS_WIDTH   = 5;
   localparam int CSR_ADDR_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [RADIUS_WIDTH-1:0]   RADIUS_RESET    = 5'd1;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_RADIUS_ADDR = 2'd0;

endpackage

FILE: sv/sliding_median_filter_top.sv
// Output: the result for position i leaves once sample i+R is taken, or at stream end; one
// result tries t candidates (up to c); c = clipped window size (up to 2R+1).
// Throughput: one sample per pass; no new sample is taken until the pass is done. A pass
// waits on rsp_tready too; the rank loop sharing the single ring read port sets its length.
// Reset: synchronous, active high; clears state, ss, nop, pointer, output beat, radius to 1.
// Ring contents are not cleared: only entries written in the current stream are read.
`include "sliding_median_filter_top_macros.svh"

module sliding_median_filter_top
   import smf_pkg::*;
#(
   parameter int MAX_RADIUS   = 31,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     req_tdata,  // sample
   input  logic                                  req_tlast,  // end_of_stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     rsp_tdata,  // median
   output logic                                  rsp_tlast,  // last_result
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0]             csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0]             csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0]             csr_prdata,
   output logic                                  csr_pready
);

   localparam int DATA_W  = ((SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int DEPTH   = 2 * MAX_RADIUS + 1;
   localparam int MAX_OUT = MAX_RADIUS + 1;
   localparam int PTR_W   = $clog2(DEPTH);
   localparam int POS_W   = $clog2(DEPTH + MAX_RADIUS + 3);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int N_W     = $clog2(MAX_OUT + 1);
   localparam int RW      = $clog2(MAX_RADIUS + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_CHECK, S_SETUP, S_CAND, S_CANDW, S_SCAN, S_TEST, S_OUT
   } state_type;

   state_type                state_ff, state_in;
   logic [RADIUS_WIDTH-1:0]  radius_ff, radius_in;
   logic [RW-1:0]            r_ff, r_in;
   logic                     end_ff, end_in;
   logic [POS_W-1:0]         ss_ff, ss_in;
   logic [POS_W-1:0]         nop_ff, nop_in;
   logic [PTR_W-1:0]         wp_ff, wp_in;
   logic [N_W-1:0]           n_ff, n_in;
   logic [POS_W-1:0]         lo_ff, lo_in;
   logic [POS_W-1:0]         hi_ff, hi_in;
   logic [CNT_W-1:0]         c_ff, c_in;
   logic [CNT_W-1:0]         k_ff, k_in;
   logic [PTR_W-1:0]         cand_slot_ff, cand_slot_in;
   logic [PTR_W-1:0]         scan_slot_ff, scan_slot_in;
   logic [CNT_W-1:0]         m_ff, m_in;
   logic                     pend_ff, pend_in;
   logic [CNT_W-1:0]         less_ff, less_in;
   logic [CNT_W-1:0]         eq_ff, eq_in;
   logic [SAMPLE_WIDTH-1:0]  cand_ff, cand_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_WIDTH-1:0]  rsp_median_ff, rsp_median_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     req_beat;
   logic                     csr_write;
   logic [PTR_W-1:0]         rd_addr;
   logic [SAMPLE_WIDTH-1:0]  rd_data;
   logic [RW-1:0]            r_clamped;
   logic [PTR_W-1:0]         wp_next;
   logic [POS_W-1:0]         ss_m1;
   logic [POS_W:0]           i_plus_r;
   logic                     go;
   logic [POS_W-1:0]         lo_a;
   logic [POS_W-1:0]         floor_pos;
   logic [POS_W-1:0]         lo_calc;
   logic [POS_W-1:0]         hi_calc;
   logic [POS_W-1:0]         span;
   logic [POS_W-1:0]         back;
   logic [POS_W:0]           slot_diff;
   logic [PTR_W-1:0]         start_slot;
   logic [PTR_W-1:0]         cand_next;
   logic [PTR_W-1:0]         scan_next;
   logic                     issue;
   logic                     is_less;
   logic                     is_eq;
   logic                     hit;
   logic                     out_free;
   logic [POS_W-1:0]         excess;

   assign req_beat  = req_tvalid && req_tready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready
                      && (csr_paddr == CSR_RADIUS_ADDR);

   assign r_clamped = (radius_ff > RADIUS_WIDTH'(MAX_RADIUS)) ? RW'(MAX_RADIUS)
                                                               : RW'(radius_ff);
   assign wp_next   = (wp_ff == PTR_W'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;

   assign ss_m1     = ss_ff - 1'b1;
   assign i_plus_r  = (POS_W+1)'(nop_ff) + (POS_W+1)'(r_ff);
   assign go        = (n_ff < N_W'(MAX_OUT)) && (nop_ff < ss_ff)
                      && (end_ff || (i_plus_r <= (POS_W+1)'(ss_m1)));
   assign lo_a      = (nop_ff >= POS_W'(r_ff)) ? nop_ff - POS_W'(r_ff) : '0;
   assign floor_pos = (ss_ff > POS_W'(DEPTH)) ? ss_ff - POS_W'(DEPTH) : '0;
   assign lo_calc   = (lo_a < floor_pos) ? floor_pos : lo_a;
   assign hi_calc   = (i_plus_r > (POS_W+1)'(ss_m1)) ? ss_m1 : POS_W'(i_plus_r);

   assign span       = hi_ff - lo_ff;
   assign back       = ss_ff - lo_ff;
   assign slot_diff  = (POS_W+1)'(wp_ff) - (POS_W+1)'(back);
   assign start_slot = slot_diff[POS_W] ? PTR_W'(slot_diff + (POS_W+1)'(DEPTH))
                                        : PTR_W'(slot_diff);

   assign cand_next = (cand_slot_ff == PTR_W'(DEPTH - 1)) ? '0 : cand_slot_ff + 1'b1;
   assign scan_next = (scan_slot_ff == PTR_W'(DEPTH - 1)) ? '0 : scan_slot_ff + 1'b1;
   assign issue     = (m_ff != c_ff);
   assign is_less   = $signed(rd_data) < $signed(cand_ff);
   assign is_eq     = (rd_data == cand_ff);
   assign hit       = (less_ff <= k_ff)
                      && ((CNT_W+1)'(k_ff) < (CNT_W+1)'(less_ff) + (CNT_W+1)'(eq_ff));
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign excess    = nop_ff - POS_W'(DEPTH);

   assign rd_addr = (state_ff == S_SCAN) ? scan_slot_ff : cand_slot_ff;

   smf_ram #(
      .WIDTH (SAMPLE_WIDTH),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (req_beat),
      .wr_addr (wp_ff),
      .wr_data (req_tdata[SAMPLE_WIDTH-1:0]),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      radius_in     = radius_ff;
      r_in          = r_ff;
      end_in        = end_ff;
      ss_in         = ss_ff;
      nop_in        = nop_ff;
      wp_in         = wp_ff;
      n_in          = n_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      c_in          = c_ff;
      k_in          = k_ff;
      cand_slot_in  = cand_slot_ff;
      scan_slot_in  = scan_slot_ff;
      m_in          = m_ff;
      pend_in       = pend_ff;
      less_in       = less_ff;
      eq_in         = eq_ff;
      cand_in       = cand_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_median_in = rsp_median_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_write) begin
         radius_in = csr_pwdata[RADIUS_WIDTH-1:0];
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               end_in   = req_tlast;
               r_in     = r_clamped;
               wp_in    = wp_next;
               ss_in    = ss_ff + 1'b1;
               n_in     = '0;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (go) begin
               lo_in    = lo_calc;
               hi_in    = hi_calc;
               state_in = S_SETUP;
            end else begin
               if (end_ff) begin
                  ss_in  = '0;
                  nop_in = '0;
                  wp_in  = '0;
               end else if (nop_ff > POS_W'(DEPTH)) begin
                  nop_in = POS_W'(DEPTH);
                  ss_in  = ss_ff - excess;
               end
               state_in = S_IDLE;
            end
         end
         S_SETUP: begin
            c_in         = CNT_W'(span) + 1'b1;
            k_in         = (CNT_W'(span) + 1'b1) >> 1;
            cand_slot_in = start_slot;
            lo_in        = lo_ff;
            state_in     = S_CAND;
         end
         S_CAND: begin
            state_in = S_CANDW;
         end
         S_CANDW: begin
            cand_in      = rd_data;
            scan_slot_in = start_slot;
            m_in         = '0;
            pend_in      = 1'b0;
            less_in      = '0;
            eq_in        = '0;
            state_in     = S_SCAN;
         end
         S_SCAN: begin
            if (issue) begin
               m_in = m_ff + 1'b1;
               if (m_ff + 1'b1 == c_ff) begin
                  scan_slot_in = scan_slot_ff;
               end else begin
                  scan_slot_in = scan_next;
               end
            end
            pend_in = issue;
            if (pend_ff) begin
               if (is_less) begin
                  less_in = less_ff + 1'b1;
               end else if (is_eq) begin
                  eq_in = eq_ff + 1'b1;
               end
            end
            if (!issue && !pend_ff) begin
               state_in = S_TEST;
            end
         end
         S_TEST: begin
            if (hit) begin
               state_in = S_OUT;
            end else begin
               cand_slot_in = cand_next;
               state_in     = S_CAND;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_median_in = cand_ff;
               rsp_last_in   = end_ff && (nop_ff == ss_m1);
               nop_in        = nop_ff + 1'b1;
               n_in          = n_ff + 1'b1;
               state_in      = S_CHECK;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         radius_ff    <= RADIUS_RESET;
         ss_ff        <= '0;
         nop_ff       <= '0;
         wp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radius_ff    <= radius_in;
         ss_ff        <= ss_in;
         nop_ff       <= nop_in;
         wp_ff        <= wp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      r_ff          <= r_in;
      end_ff        <= end_in;
      n_ff          <= n_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      c_ff          <= c_in;
      k_ff          <= k_in;
      cand_slot_ff  <= cand_slot_in;
      scan_slot_ff  <= scan_slot_in;
      m_ff          <= m_in;
      pend_ff       <= pend_in;
      less_ff       <= less_in;
      eq_ff         <= eq_in;
      cand_ff       <= cand_in;
      rsp_median_ff <= rsp_median_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'(rsp_median_ff);
   assign rsp_tlast  = rsp_last_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_RADIUS_ADDR) ? CSR_DATA_WIDTH'(radius_ff) : '0;

   `SMF_ASSERT_IMP(a_idle_lag, state_ff == S_IDLE, (ss_ff >= nop_ff) && (ss_ff - nop_ff <= POS_W'(MAX_RADIUS + 1)), "pending positions exceed radius bound")
   `SMF_ASSERT_IMP(a_out_rank, state_ff == S_OUT, hit, "emitted candidate is not the upper median")
   `SMF_ASSERT_IMP(a_scan_bound, state_ff == S_SCAN, (m_ff <= c_ff) && (c_ff != '0), "rank scan ran past window")
   `SMF_ASSERT_NXT(a_flush_clear, (state_ff == S_CHECK) && !go && end_ff, (ss_ff == '0) && (nop_ff == '0) && (wp_ff == '0), "stream end did not clear counters")

endmodule

FILE: sv/smf_ram.sv
module smf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 63
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
